// ===== hdl/mips_instruction_decoder_core_macros.svh =====
// Assertion macros for the decoder top level.
// Depends on nothing; assertions compile away when SYNTHESIS is defined.
`ifndef MIPS_INSTRUCTION_DECODER_CORE_MACROS_SVH
`define MIPS_INSTRUCTION_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MIPSDEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MIPSDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MIPSDEC_ASSERT_NOW(label, clk, rst, ante, cons)
`define MIPSDEC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/mipsdec_pkg.sv =====
// Types, opcode and funct codes and the format lookup for the MIPS decoder.
// Depends on nothing; used by mipsdec_decode and the top level.
package mipsdec_pkg;

   localparam int WORD_W = 32;
   localparam int RSP_W  = 104;

   typedef enum logic [5:0] {
      MN_SLTU, MN_SLT, MN_NOR, MN_XOR, MN_OR, MN_AND, MN_SUBU, MN_SUB,
      MN_ADDU, MN_ADD, MN_SRAV, MN_SRLV, MN_SLLV, MN_SRL, MN_SLL, MN_SRA,
      MN_DIVU, MN_DIV, MN_MULTU, MN_MULT, MN_JALR, MN_MTLO, MN_MTHI, MN_JR,
      MN_MFLO, MN_MFHI, MN_SYSCALL, MN_J, MN_JAL, MN_BEQ, MN_BNE, MN_ADDI,
      MN_ADDIU, MN_SLTI, MN_SLTIU, MN_ANDI, MN_ORI, MN_XORI, MN_LUI, MN_LB,
      MN_LH, MN_LW, MN_LBU, MN_LHU, MN_SB, MN_SH, MN_SW, MN_UNKNOWN
   } mnemonic_type;

   typedef enum logic [3:0] {
      FMT_ARITH3, FMT_VSHIFT, FMT_CSHIFT, FMT_MULDIV, FMT_RS_ONLY, FMT_RD_ONLY,
      FMT_SYSCALL, FMT_JUMP, FMT_BRANCH, FMT_IMM, FMT_LUI, FMT_MEM, FMT_UNKNOWN
   } format_type;

   typedef struct packed {
      mnemonic_type mnemonic;
      format_type   fmt;
   } decode_type;

   // opcode field values
   localparam logic [5:0] OP_SPECIAL = 6'h00, OP_J    = 6'h02, OP_JAL   = 6'h03,
                          OP_BEQ     = 6'h04, OP_BNE  = 6'h05, OP_ADDI  = 6'h08,
                          OP_ADDIU   = 6'h09, OP_SLTI = 6'h0A, OP_SLTIU = 6'h0B,
                          OP_ANDI    = 6'h0C, OP_ORI  = 6'h0D, OP_XORI  = 6'h0E,
                          OP_LUI     = 6'h0F, OP_LB   = 6'h20, OP_LH    = 6'h21,
                          OP_LW      = 6'h23, OP_LBU  = 6'h24, OP_LHU   = 6'h25,
                          OP_SB      = 6'h28, OP_SH   = 6'h29, OP_SW    = 6'h2B;

   // funct field values for the special opcode
   localparam logic [5:0] FN_SLL  = 6'h00, FN_SRL   = 6'h02, FN_SRA   = 6'h03,
                          FN_SLLV = 6'h04, FN_SRLV  = 6'h06, FN_SRAV  = 6'h07,
                          FN_JR   = 6'h08, FN_JALR  = 6'h09, FN_SYSC  = 6'h0C,
                          FN_MFHI = 6'h10, FN_MTHI  = 6'h11, FN_MFLO  = 6'h12,
                          FN_MTLO = 6'h13, FN_MULT  = 6'h18, FN_MULTU = 6'h19,
                          FN_DIV  = 6'h1A, FN_DIVU  = 6'h1B, FN_ADD   = 6'h20,
                          FN_ADDU = 6'h21, FN_SUB   = 6'h22, FN_SUBU  = 6'h23,
                          FN_AND  = 6'h24, FN_OR    = 6'h25, FN_XOR   = 6'h26,
                          FN_NOR  = 6'h27, FN_SLT   = 6'h2A, FN_SLTU  = 6'h2B;

   function automatic format_type format_of(input mnemonic_type mn);
      format_type f;
      case (mn)
         MN_SLTU, MN_SLT, MN_NOR, MN_XOR, MN_OR, MN_AND, MN_SUBU, MN_SUB,
         MN_ADDU, MN_ADD:                    f = FMT_ARITH3;
         MN_SRAV, MN_SRLV, MN_SLLV:          f = FMT_VSHIFT;
         MN_SRL, MN_SLL, MN_SRA:             f = FMT_CSHIFT;
         MN_DIVU, MN_DIV, MN_MULTU, MN_MULT: f = FMT_MULDIV;
         MN_JALR, MN_MTLO, MN_MTHI, MN_JR:   f = FMT_RS_ONLY;
         MN_MFLO, MN_MFHI:                   f = FMT_RD_ONLY;
         MN_SYSCALL:                         f = FMT_SYSCALL;
         MN_J, MN_JAL:                       f = FMT_JUMP;
         MN_BEQ, MN_BNE:                     f = FMT_BRANCH;
         MN_ADDI, MN_ADDIU, MN_SLTI, MN_SLTIU, MN_ANDI, MN_ORI,
         MN_XORI:                            f = FMT_IMM;
         MN_LUI:                             f = FMT_LUI;
         MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU, MN_SB, MN_SH,
         MN_SW:                              f = FMT_MEM;
         default:                            f = FMT_UNKNOWN;
      endcase
      return f;
   endfunction

endpackage

// ===== hdl/mipsdec_decode.sv =====
// Opcode/funct decode of one instruction word into mnemonic and format class.
// Depends on mipsdec_pkg.
module mipsdec_decode (
   input  logic [mipsdec_pkg::WORD_W-1:0] word,
   output mipsdec_pkg::decode_type        result
);
   import mipsdec_pkg::*;

   logic [5:0]   opcode;
   logic [5:0]   funct;
   mnemonic_type mn;

   assign opcode = word[31:26];
   assign funct  = word[5:0];

   always_comb begin
      mn = MN_UNKNOWN;
      if (opcode == OP_SPECIAL) begin
         case (funct)
            FN_SLL:   mn = MN_SLL;
            FN_SRL:   mn = MN_SRL;
            FN_SRA:   mn = MN_SRA;
            FN_SLLV:  mn = MN_SLLV;
            FN_SRLV:  mn = MN_SRLV;
            FN_SRAV:  mn = MN_SRAV;
            FN_JR:    mn = MN_JR;
            FN_JALR:  mn = MN_JALR;
            FN_SYSC:  mn = MN_SYSCALL;
            FN_MFHI:  mn = MN_MFHI;
            FN_MTHI:  mn = MN_MTHI;
            FN_MFLO:  mn = MN_MFLO;
            FN_MTLO:  mn = MN_MTLO;
            FN_MULT:  mn = MN_MULT;
            FN_MULTU: mn = MN_MULTU;
            FN_DIV:   mn = MN_DIV;
            FN_DIVU:  mn = MN_DIVU;
            FN_ADD:   mn = MN_ADD;
            FN_ADDU:  mn = MN_ADDU;
            FN_SUB:   mn = MN_SUB;
            FN_SUBU:  mn = MN_SUBU;
            FN_AND:   mn = MN_AND;
            FN_OR:    mn = MN_OR;
            FN_XOR:   mn = MN_XOR;
            FN_NOR:   mn = MN_NOR;
            FN_SLT:   mn = MN_SLT;
            FN_SLTU:  mn = MN_SLTU;
            default:  mn = MN_UNKNOWN;
         endcase
      end else begin
         case (opcode)
            OP_J:     mn = MN_J;
            OP_JAL:   mn = MN_JAL;
            OP_BEQ:   mn = MN_BEQ;
            OP_BNE:   mn = MN_BNE;
            OP_ADDI:  mn = MN_ADDI;
            OP_ADDIU: mn = MN_ADDIU;
            OP_SLTI:  mn = MN_SLTI;
            OP_SLTIU: mn = MN_SLTIU;
            OP_ANDI:  mn = MN_ANDI;
            OP_ORI:   mn = MN_ORI;
            OP_XORI:  mn = MN_XORI;
            OP_LUI:   mn = MN_LUI;
            OP_LB:    mn = MN_LB;
            OP_LH:    mn = MN_LH;
            OP_LW:    mn = MN_LW;
            OP_LBU:   mn = MN_LBU;
            OP_LHU:   mn = MN_LHU;
            OP_SB:    mn = MN_SB;
            OP_SH:    mn = MN_SH;
            OP_SW:    mn = MN_SW;
            default:  mn = MN_UNKNOWN;
         endcase
      end
   end

   assign result.mnemonic = mn;
   assign result.fmt      = format_of(mn);

endmodule

// ===== hdl/mips_instruction_decoder_core.sv =====
// MIPS32 instruction decoder, top level.
// Depends on mipsdec_pkg, mipsdec_decode and the assertion macro header.
//
// Usage:
//   req channel: one request per instruction word. req_tdata carries the
//   32-bit word, req_tlast marks the final word of a program.
//   rsp channel: one result per request, in order. rsp_tdata carries the
//   running item index, the mnemonic code, the format class, the rs, rt,
//   rd and shamt fields, the raw 16-bit immediate and the jump target.
//   Path: an accepted request is held in the input register, then decoded
//   into the result register, which drives rsp_tvalid and rsp_tdata.
//   Throughput: one request per cycle; the decode is a shallow opcode/funct
//   table between the two registers, and the two pipeline registers stall
//   together only when the receiver holds rsp_tready low with both full.
//   Item index: counts accepted requests from zero; the request that carries
//   req_tlast keeps its own index and the count restarts at zero after it.
//   Reset (synchronous, active high): empty both stages, clear the index.
//   Receiver stall: hold the result; the input stage keeps taking a request
//   until it is full too, then req_tready drops.
module mips_instruction_decoder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mipsdec_pkg::WORD_W-1:0] req_tdata,  // [31:0] instruction_word
   input  logic                           req_tlast,  // last_word
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] item_index, [37:32] mnemonic, [41:38] format_class,
   // [46:42] src_reg, [51:47] tgt_reg, [56:52] dst_reg,
   // [61:57] shift_amount, [77:62] immediate, [103:78] jump_target
   output logic [mipsdec_pkg::RSP_W-1:0]  rsp_tdata
);
   import mipsdec_pkg::*;

`include "mips_instruction_decoder_core_macros.svh"

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] in_word_ff, in_word_in;
   logic [31:0]       in_index_ff, in_index_in;
   // running index of the next request
   logic [31:0]       index_ff, index_in;
   // result stage
   logic              out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]  out_data_ff, out_data_in;

   logic       req_fire;
   logic       out_advance;
   logic       in_advance;
   decode_type dec;

   // The result stage moves when it is empty or being drained; the input
   // stage moves when it is empty or hands its request on.
   assign out_advance = !out_valid_ff || rsp_tready;
   assign in_advance  = !in_valid_ff || out_advance;
   assign req_tready  = in_advance;
   assign req_fire    = req_tvalid && req_tready;

   mipsdec_decode u_decode (
      .word   (in_word_ff),
      .result (dec)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      in_index_in = in_index_ff;
      index_in    = index_ff;
      if (in_advance) begin
         in_valid_in = req_fire;
      end
      if (req_fire) begin
         in_word_in  = req_tdata;
         in_index_in = index_ff;
         // restart the count after the last word of a program
         index_in    = req_tlast ? 32'd0 : index_ff + 32'd1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_data_in = {in_word_ff[25:0],   // jump_target
                           in_word_ff[15:0],   // immediate
                           in_word_ff[10:6],   // shift_amount
                           in_word_ff[15:11],  // dst_reg
                           in_word_ff[20:16],  // tgt_reg
                           in_word_ff[25:21],  // src_reg
                           dec.fmt,
                           dec.mnemonic,
                           in_index_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         index_ff     <= 32'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         index_ff     <= index_in;
      end
      in_word_ff  <= in_word_in;
      in_index_ff <= in_index_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // the count restarts after a last word and steps by one otherwise
   `MIPSDEC_ASSERT_NEXT(a_index_restart, clock, reset, req_fire && req_tlast, index_ff == 32'd0)
   `MIPSDEC_ASSERT_NEXT(a_index_step, clock, reset, req_fire && !req_tlast,
                        index_ff == $past(index_ff) + 32'd1)
   // unknown mnemonic and unknown format go together
   `MIPSDEC_ASSERT_NOW(a_unknown_pair, clock, reset, out_valid_ff,
      (out_data_ff[37:32] == MN_UNKNOWN) == (out_data_ff[41:38] == FMT_UNKNOWN))
   // a full input stage behind a stalled result holds its request
   `MIPSDEC_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !out_advance,
                        in_valid_ff && $stable(in_word_ff) && $stable(in_index_ff))

endmodule

// ===== dv/tb_mips_instruction_decoder_core.sv =====
// Self-checking testbench for the MIPS32 instruction decoder core.
// Depends on mipsdec_pkg for the mnemonic, format and opcode/funct codes.
`timescale 1ns / 100ps

module tb_mips_instruction_decoder_core;
   import mipsdec_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 8;

   // result fields, MSB first so the struct overlays rsp_tdata bit for bit
   typedef struct packed {
      logic [25:0]        jump_target;
      logic signed [15:0] immediate;
      logic [4:0]         shift_amount;
      logic [4:0]         dst_reg;
      logic [4:0]         tgt_reg;
      logic [4:0]         src_reg;
      format_type         fmt;
      mnemonic_type       mnemonic;
      logic [31:0]        item_index;
   } decoded_fields_type;

   localparam logic [5:0] SPECIAL_FUNCTS [0:26] = '{
      FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR, FN_SYSC,
      FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
      FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT,
      FN_SLTU};

   localparam logic [5:0] MAIN_OPCODES [0:19] = '{
      OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
      OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
      OP_SB, OP_SH, OP_SW};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [WORD_W-1:0]    req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;

   decoded_fields_type   pending_decodes [$];
   logic [31:0]          program_index = '0;
   int                   error_count = 0;
   int                   cycle_count = 0;
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   holdoff_left = 0;

   mips_instruction_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Decode one word the way the block should: table lookup on the opcode,
   // then on funct for the special opcode; all register and immediate
   // fields are raw slices whatever the class.
   function automatic decoded_fields_type decode_word(logic [31:0] word, logic [31:0] idx);
      decoded_fields_type d;
      d.item_index   = idx;
      d.src_reg      = word[25:21];
      d.tgt_reg      = word[20:16];
      d.dst_reg      = word[15:11];
      d.shift_amount = word[10:6];
      d.immediate    = word[15:0];
      d.jump_target  = word[25:0];
      d.mnemonic     = MN_UNKNOWN;
      d.fmt          = FMT_UNKNOWN;
      case (word[31:26])
         OP_SPECIAL: begin
            case (word[5:0])
               FN_SLL:   begin d.mnemonic = MN_SLL;     d.fmt = FMT_CSHIFT;  end
               FN_SRL:   begin d.mnemonic = MN_SRL;     d.fmt = FMT_CSHIFT;  end
               // shift right arithmetic has its own code, not sll's
               FN_SRA:   begin d.mnemonic = MN_SRA;     d.fmt = FMT_CSHIFT;  end
               FN_SLLV:  begin d.mnemonic = MN_SLLV;    d.fmt = FMT_VSHIFT;  end
               FN_SRLV:  begin d.mnemonic = MN_SRLV;    d.fmt = FMT_VSHIFT;  end
               FN_SRAV:  begin d.mnemonic = MN_SRAV;    d.fmt = FMT_VSHIFT;  end
               FN_JR:    begin d.mnemonic = MN_JR;      d.fmt = FMT_RS_ONLY; end
               FN_JALR:  begin d.mnemonic = MN_JALR;    d.fmt = FMT_RS_ONLY; end
               FN_SYSC:  begin d.mnemonic = MN_SYSCALL; d.fmt = FMT_SYSCALL; end
               FN_MFHI:  begin d.mnemonic = MN_MFHI;    d.fmt = FMT_RD_ONLY; end
               FN_MTHI:  begin d.mnemonic = MN_MTHI;    d.fmt = FMT_RS_ONLY; end
               FN_MFLO:  begin d.mnemonic = MN_MFLO;    d.fmt = FMT_RD_ONLY; end
               FN_MTLO:  begin d.mnemonic = MN_MTLO;    d.fmt = FMT_RS_ONLY; end
               FN_MULT:  begin d.mnemonic = MN_MULT;    d.fmt = FMT_MULDIV;  end
               FN_MULTU: begin d.mnemonic = MN_MULTU;   d.fmt = FMT_MULDIV;  end
               FN_DIV:   begin d.mnemonic = MN_DIV;     d.fmt = FMT_MULDIV;  end
               FN_DIVU:  begin d.mnemonic = MN_DIVU;    d.fmt = FMT_MULDIV;  end
               FN_ADD:   begin d.mnemonic = MN_ADD;     d.fmt = FMT_ARITH3;  end
               FN_ADDU:  begin d.mnemonic = MN_ADDU;    d.fmt = FMT_ARITH3;  end
               FN_SUB:   begin d.mnemonic = MN_SUB;     d.fmt = FMT_ARITH3;  end
               FN_SUBU:  begin d.mnemonic = MN_SUBU;    d.fmt = FMT_ARITH3;  end
               FN_AND:   begin d.mnemonic = MN_AND;     d.fmt = FMT_ARITH3;  end
               FN_OR:    begin d.mnemonic = MN_OR;      d.fmt = FMT_ARITH3;  end
               FN_XOR:   begin d.mnemonic = MN_XOR;     d.fmt = FMT_ARITH3;  end
               FN_NOR:   begin d.mnemonic = MN_NOR;     d.fmt = FMT_ARITH3;  end
               FN_SLT:   begin d.mnemonic = MN_SLT;     d.fmt = FMT_ARITH3;  end
               FN_SLTU:  begin d.mnemonic = MN_SLTU;    d.fmt = FMT_ARITH3;  end
               default: ;
            endcase
         end
         OP_J:     begin d.mnemonic = MN_J;     d.fmt = FMT_JUMP;   end
         OP_JAL:   begin d.mnemonic = MN_JAL;   d.fmt = FMT_JUMP;   end
         OP_BEQ:   begin d.mnemonic = MN_BEQ;   d.fmt = FMT_BRANCH; end
         OP_BNE:   begin d.mnemonic = MN_BNE;   d.fmt = FMT_BRANCH; end
         OP_ADDI:  begin d.mnemonic = MN_ADDI;  d.fmt = FMT_IMM;    end
         OP_ADDIU: begin d.mnemonic = MN_ADDIU; d.fmt = FMT_IMM;    end
         OP_SLTI:  begin d.mnemonic = MN_SLTI;  d.fmt = FMT_IMM;    end
         OP_SLTIU: begin d.mnemonic = MN_SLTIU; d.fmt = FMT_IMM;    end
         // and-immediate has its own code, not addi's
         OP_ANDI:  begin d.mnemonic = MN_ANDI;  d.fmt = FMT_IMM;    end
         OP_ORI:   begin d.mnemonic = MN_ORI;   d.fmt = FMT_IMM;    end
         OP_XORI:  begin d.mnemonic = MN_XORI;  d.fmt = FMT_IMM;    end
         OP_LUI:   begin d.mnemonic = MN_LUI;   d.fmt = FMT_LUI;    end
         OP_LB:    begin d.mnemonic = MN_LB;    d.fmt = FMT_MEM;    end
         OP_LH:    begin d.mnemonic = MN_LH;    d.fmt = FMT_MEM;    end
         OP_LW:    begin d.mnemonic = MN_LW;    d.fmt = FMT_MEM;    end
         OP_LBU:   begin d.mnemonic = MN_LBU;   d.fmt = FMT_MEM;    end
         OP_LHU:   begin d.mnemonic = MN_LHU;   d.fmt = FMT_MEM;    end
         OP_SB:    begin d.mnemonic = MN_SB;    d.fmt = FMT_MEM;    end
         OP_SH:    begin d.mnemonic = MN_SH;    d.fmt = FMT_MEM;    end
         OP_SW:    begin d.mnemonic = MN_SW;    d.fmt = FMT_MEM;    end
         default: ;
      endcase
      return d;
   endfunction

   // Mostly well-formed words with random operand bits; the rest is noise:
   // special opcode with any funct, or a fully random word.
   function automatic logic [31:0] random_word();
      int          pick;
      logic [31:0] w;
      pick = $urandom_range(99);
      w = $urandom;
      if (pick < 40)
         w = {OP_SPECIAL, w[25:6], SPECIAL_FUNCTS[$urandom_range(26)]};
      else if (pick < 80)
         w = {MAIN_OPCODES[$urandom_range(19)], w[25:0]};
      else if (pick < 90)
         w = {OP_SPECIAL, w[25:0]};
      return w;
   endfunction

   task automatic report_error(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Offer one request, with random idle cycles ahead of it; return once accepted.
   // Valid stays high on return so back-to-back requests never drop it.
   task automatic send_word(logic [31:0] word, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every expected result has come back.
   // Wait on the clock before the first check so the last accepted request is already queued.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_decodes.size() != 0);
   endtask

   task automatic set_idling(int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Every mnemonic once, with random operand bits; each group is one program.
   task automatic test_every_mnemonic();
      logic [31:0] r;
      set_idling(0, 0);
      for (int k = 0; k < 27; k++) begin
         r = $urandom;
         send_word({OP_SPECIAL, r[25:6], SPECIAL_FUNCTS[k]}, k == 26);
      end
      for (int k = 0; k < 20; k++) begin
         r = $urandom;
         send_word({MAIN_OPCODES[k], r[25:0]}, k == 19);
      end
   endtask

   // Field extremes, unknown opcode and funct, and single-word programs.
   task automatic test_edge_words();
      set_idling(0, 0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word({OP_SPECIAL, 20'hFFFFF, 6'h01}, 1'b0);
      send_word({6'h01, 26'h0000000}, 1'b1);
      send_word({OP_ADDI, 10'h3FF, 16'h8000}, 1'b1);
      send_word({OP_ORI, 10'h000, 16'h7FFF}, 1'b1);
      send_word({OP_J, 26'h3FFFFFF}, 1'b0);
      send_word({OP_SPECIAL, 20'h00000, 6'h3F}, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_stream(int count, int idle_pct, int stall_pct);
      set_idling(idle_pct, stall_pct);
      for (int n = 0; n < count; n++)
         send_word(random_word(), $urandom_range(15) == 0);
      wait_drained();
   endtask

   // Hold the receiver off for a long stretch while requests keep coming,
   // so both pipeline stages fill and req_tready drops.
   task automatic test_backpressure();
      set_idling(0, 0);
      holdoff_left = 80;
      for (int n = 0; n < 40; n++)
         send_word(random_word(), $urandom_range(15) == 0);
      wait_drained();
   endtask

   // Receiver: random stalls, or a forced hold-off when one is requested.
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Predict each accepted request and advance the program index.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pending_decodes.push_back(decode_word(req_tdata, program_index));
         program_index = req_tlast ? 32'd0 : program_index + 32'd1;
      end
   end

   // Compare each accepted result with the oldest prediction, field by field.
   always @(posedge clock) begin
      decoded_fields_type got;
      decoded_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_decodes.size() == 0) begin
            report_error($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want = pending_decodes.pop_front();
            if (got.item_index !== want.item_index)
               report_error($sformatf("item_index got %0d want %0d",
                                      got.item_index, want.item_index));
            if (got.mnemonic !== want.mnemonic)
               report_error($sformatf("mnemonic got %0d want %0d",
                                      got.mnemonic, want.mnemonic));
            if (got.fmt !== want.fmt)
               report_error($sformatf("format_class got %0d want %0d", got.fmt, want.fmt));
            if (got.src_reg !== want.src_reg)
               report_error($sformatf("src_reg got %0d want %0d", got.src_reg, want.src_reg));
            if (got.tgt_reg !== want.tgt_reg)
               report_error($sformatf("tgt_reg got %0d want %0d", got.tgt_reg, want.tgt_reg));
            if (got.dst_reg !== want.dst_reg)
               report_error($sformatf("dst_reg got %0d want %0d", got.dst_reg, want.dst_reg));
            if (got.shift_amount !== want.shift_amount)
               report_error($sformatf("shift_amount got %0d want %0d",
                                      got.shift_amount, want.shift_amount));
            if (got.immediate !== want.immediate)
               report_error($sformatf("immediate got %0d want %0d",
                                      got.immediate, want.immediate));
            if (got.jump_target !== want.jump_target)
               report_error($sformatf("jump_target got %h want %h",
                                      got.jump_target, want.jump_target));
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_decodes.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_every_mnemonic();
      test_edge_words();
      test_random_stream(300, 0, 0);
      test_random_stream(300, 88, 0);
      test_random_stream(300, 0, 88);
      test_random_stream(300, 7, 7);
      test_backpressure();
      test_random_stream(160, 30, 30);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_decodes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
